/* src/uchk_pkg.sv */
// ----------------------------------------------------------------------------
// uchk_pkg
// Shared types, constants and byte classification functions for the UTF-8
// text plausibility checker.
// ----------------------------------------------------------------------------
package uchk_pkg;

   localparam int ByteW   = 8;
   localparam int ContW   = 3;
   localparam int BomW    = 2;
   localparam int RspDataW = 8;

   localparam logic [ByteW-1:0] BomLead   = 8'hef;
   localparam logic [ByteW-1:0] BomSecond = 8'hbb;
   localparam logic [ByteW-1:0] BomThird  = 8'hbf;

   localparam logic [BomW-1:0] BomNone      = 2'd0;
   localparam logic [BomW-1:0] BomWantThird = 2'd1;
   localparam logic [BomW-1:0] BomWantSecond = 2'd2;

   localparam logic [ContW-1:0] ContMax = 3'd5;

   typedef struct packed {
      logic [ContW-1:0] cont_left;
      logic [BomW-1:0]  bom_left;
      logic             seen_invalid;
   } state_type;

   localparam state_type StateReset = '{cont_left: '0, bom_left: BomNone, seen_invalid: 1'b0};

   function automatic logic [ContW-1:0] lead_length(input logic [ByteW-1:0] b);
      logic [ContW-1:0] n;
      n = '0;
      priority if ((b & 8'he0) == 8'hc0) n = 3'd1;
      else if ((b & 8'hf0) == 8'he0) n = 3'd2;
      else if ((b & 8'hf8) == 8'hf0) n = 3'd3;
      else if ((b & 8'hfc) == 8'hf8) n = 3'd4;
      else if ((b & 8'hfe) == 8'hfc) n = 3'd5;
      else n = 3'd0;
      return n;
   endfunction

   function automatic logic plain_ok(input logic [ByteW-1:0] b);
      return ((b >= 8'd9) && (b <= 8'd13)) || ((b >= 8'd32) && (b <= 8'd127));
   endfunction

   function automatic logic is_cont(input logic [ByteW-1:0] b);
      return (b & 8'hc0) == 8'h80;
   endfunction

endpackage

/* src/uchk_decode.sv */
// ----------------------------------------------------------------------------
// uchk_decode
// Per-byte decoder: next checker state and verdict from current state and
// one text byte.
// ----------------------------------------------------------------------------
module uchk_decode
   import uchk_pkg::*;
(
   input  state_type        state_cur,
   input  logic [ByteW-1:0] text_byte,
   input  logic             last_byte,
   output state_type        state_nxt,
   output logic             text_ok
);

   state_type        upd;
   logic             bad;
   logic [ContW-1:0] lead_n;

   assign lead_n = lead_length(text_byte);

   always_comb begin
      upd = state_cur;
      bad = 1'b0;
      priority if (state_cur.bom_left != BomNone) begin
         if (text_byte == ((state_cur.bom_left == BomWantSecond) ? BomSecond : BomThird)) begin
            upd.bom_left = state_cur.bom_left - 2'd1;
         end else begin
            bad          = 1'b1;
            upd.bom_left = BomNone;
         end
      end else if (state_cur.cont_left != '0) begin
         if (is_cont(text_byte)) begin
            upd.cont_left = state_cur.cont_left - 3'd1;
         end else begin
            bad           = 1'b1;
            upd.cont_left = '0;
         end
      end else if (!text_byte[ByteW-1]) begin
         bad = !plain_ok(text_byte);
      end else if (text_byte == BomLead) begin
         upd.bom_left = BomWantSecond;
      end else if (lead_n == '0) begin
         bad = 1'b1;
      end else begin
         upd.cont_left = lead_n;
      end
      upd.seen_invalid = state_cur.seen_invalid | bad;
   end

   assign text_ok   = !upd.seen_invalid;
   assign state_nxt = last_byte ? StateReset : upd;

endmodule

/* src/utf8_text_plausibility_checker.sv */
// ----------------------------------------------------------------------------
// utf8_text_plausibility_checker
// Judges a plaintext byte stream as text: plain bytes, BOM, multibyte leads.
// ----------------------------------------------------------------------------
// An accepted byte passes the input register, then the result register on rsp.
// Throughput: one byte per cycle unless rsp stalls; the state update in
// uchk_decode sits between the input register and the result register.
// Reset: synchronous, active high; clears both valid flags and the decoder
// state, so the first byte after reset opens a fresh buffer.
module utf8_text_plausibility_checker
   import uchk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                req_tlast,   // last_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [0] text_ok, [7:1] zero
   output logic                rsp_tlast    // buffer_done
);

   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_ok_ff;
   logic             out_last_ff;
   state_type        state_ff, state_in;
   state_type        state_dec;
   logic             ok_dec;
   logic             advance;
   logic             move;

   uchk_decode u_decode (
      .state_cur (state_ff),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_nxt (state_dec),
      .text_ok   (ok_dec)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = advance && in_valid_ff;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;
   assign state_in     = move ? state_dec : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (move) begin
         out_ok_ff   <= ok_dec;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW-1){1'b0}}, out_ok_ff};
   assign rsp_tlast  = out_last_ff;

   a_cont_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.cont_left <= ContMax)
      else $error("continuation count out of range");

   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      !((state_ff.cont_left != '0) && (state_ff.bom_left != BomNone)))
      else $error("mark and multibyte sequence pending together");

   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (move && in_last_ff) |=> (state_ff == StateReset))
      else $error("state not cleared after last byte");

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (move && !in_last_ff && state_ff.seen_invalid) |=> state_ff.seen_invalid)
      else $error("reject flag dropped inside a buffer");

   a_verdict_matches: assert property (@(posedge clock) disable iff (reset)
      (move) |=> (out_ok_ff == !$past(state_dec.seen_invalid) || $past(in_last_ff)))
      else $error("verdict disagrees with decoder state");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams plaintext bytes into the UTF-8 text plausibility checker in buffers
// of mostly well-formed text (plain bytes, marks, multibyte runs) with noise
// and broken runs mixed in. Each verdict word is checked against a
// behavioural copy of the decoder, with random gaps on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import uchk_pkg::*;

   typedef struct packed {
      logic             last_byte;
      logic [ByteW-1:0] text_byte;
   } text_word_type;

   typedef struct packed {
      logic text_ok;
      logic buffer_done;
   } verdict_type;

   localparam int unsigned RandomBytes = 1950;
   localparam int unsigned QuietFrom   = 600;
   localparam int unsigned QuietTo     = 1100;
   localparam int unsigned HoldAt      = 1800;
   localparam int unsigned HoldLen     = 300;

   // {last, byte}: plain extremes, rejection persisting, mark, broken mark,
   // six-byte run, broken run, run left open at buffer end, stray bytes
   localparam logic [8:0] Directed [25] = '{
      9'h009, 9'h07f, 9'h00d, 9'h120,
      9'h100,
      9'h1ff,
      9'h01f, 9'h141,
      9'h0ef, 9'h0bb, 9'h1bf,
      9'h0ef, 9'h141,
      9'h0fc, 9'h080, 9'h080, 9'h080, 9'h080, 9'h1bf,
      9'h0c2, 9'h141,
      9'h0e0, 9'h180,
      9'h10e,
      9'h180
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ByteW-1:0]    req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;

   text_word_type byte_queue [$];
   verdict_type   verdict_queue [$];
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   int unsigned errors = 0;

   logic [ContW-1:0] cont_pending = '0;
   logic [BomW-1:0]  mark_pending = BomNone;
   logic             rejected = 1'b0;

   wire quiet = (cycle_count >= QuietFrom) && (cycle_count < QuietTo);

   utf8_text_plausibility_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic verdict_type judge_byte(input logic [ByteW-1:0] b, input logic last);
      logic             bad;
      logic [ContW-1:0] n;
      verdict_type      v;
      bad = 1'b0;
      if (mark_pending != BomNone) begin
         if (b == ((mark_pending == BomWantSecond) ? BomSecond : BomThird)) begin
            mark_pending = mark_pending - 2'd1;
         end else begin
            bad = 1'b1;
            mark_pending = BomNone;
         end
      end else if (cont_pending != '0) begin
         if (b[7:6] == 2'b10) begin
            cont_pending = cont_pending - 3'd1;
         end else begin
            bad = 1'b1;
            cont_pending = '0;
         end
      end else if (!b[7]) begin
         bad = !((b >= 8'd9 && b <= 8'd13) || b >= 8'd32);
      end else if (b == BomLead) begin
         mark_pending = BomWantSecond;
      end else begin
         casez (b)
            8'b110?????: n = 3'd1;
            8'b1110????: n = 3'd2;
            8'b11110???: n = 3'd3;
            8'b111110??: n = 3'd4;
            8'b1111110?: n = 3'd5;
            default:     n = 3'd0;
         endcase
         if (n == 3'd0) bad = 1'b1;
         else cont_pending = n;
      end
      if (bad) rejected = 1'b1;
      v.text_ok = !rejected;
      v.buffer_done = last;
      if (last) begin
         cont_pending = '0;
         mark_pending = BomNone;
         rejected = 1'b0;
      end
      return v;
   endfunction

   // one buffer of text tokens; a broken run or noise may leave a run open
   task automatic add_random_buffer();
      logic [ByteW-1:0] part [$];
      int unsigned      len, pick, n, k;
      logic [ByteW-1:0] lead;
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
      while (part.size() < len) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(9) == 0) part.push_back(8'($urandom_range(13, 9)));
            else part.push_back(8'($urandom_range(127, 32)));
         end else if (pick < 55) begin
            part.push_back(BomLead);
            part.push_back(BomSecond);
            part.push_back(BomThird);
         end else if (pick < 80 || (pick >= 90 && pick < 95)) begin
            n = $urandom_range(5, 1);
            case (n)
               1: lead = 8'hc0 | 8'($urandom_range(31));
               2: lead = 8'he0 | 8'($urandom_range(15));
               3: lead = 8'hf0 | 8'($urandom_range(7));
               4: lead = 8'hf8 | 8'($urandom_range(3));
               default: lead = 8'hfc | 8'($urandom_range(1));
            endcase
            if (lead == BomLead) lead = 8'hee;
            part.push_back(lead);
            k = (pick < 80) ? n : $urandom_range(n - 1);
            repeat (k) part.push_back(8'h80 | 8'($urandom_range(63)));
         end else if (pick < 90) begin
            part.push_back(8'($urandom_range(255)));
         end else begin
            part.push_back(BomLead);
            if ($urandom_range(1) == 1) part.push_back(BomSecond);
         end
      end
      for (int i = 0; i < part.size(); i++) begin
         byte_queue.push_back('{last_byte: (i == part.size() - 1), text_byte: part[i]});
      end
   endtask

   always @(posedge clock) begin
      if (!reset) cycle_count <= cycle_count + 1;
   end

   // driver
   always @(posedge clock) begin
      text_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_queue.push_back(judge_byte(req_tdata, req_tlast));
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
               w = byte_queue.pop_front();
               req_tdata <= w.text_byte;
               req_tlast <= w.last_byte;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict word tdata=%h tlast=%0b",
                        $time, rsp_tdata, rsp_tlast);
               errors <= errors + 1;
            end else begin
               v = verdict_queue.pop_front();
               if (rsp_tdata != {7'b0, v.text_ok} || rsp_tlast != v.buffer_done) begin
                  $display("%0t: verdict mismatch expected tdata=%h tlast=%0b %s",
                           $time, {7'b0, v.text_ok}, v.buffer_done,
                           $sformatf("got tdata=%h tlast=%0b", rsp_tdata, rsp_tlast));
                  errors <= errors + 1;
               end
            end
         end
         if (cycle_count == HoldAt) begin
            hold_left <= HoldLen;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 30);
         end
      end
   end

   initial begin
      foreach (Directed[i]) begin
         byte_queue.push_back(Directed[i]);
      end
      while (byte_queue.size() < RandomBytes + 25) add_random_buffer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (byte_queue.size() != 0 || req_tvalid) @(negedge clock);
      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0 && verdict_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
